@@ rtl/core/mhpq_pkg.sv @@
// Package for the max-heap priority queue: sizes, types and status codes.
// Used by mhpq_cell and max_heap_priority_queue; depends on nothing.
package mhpq_pkg;

	localparam int CAPACITY = 64;
	localparam int KEY_W    = 32;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [1:0]              status_t;

	localparam logic    CMD_INSERT  = 1'b0;
	localparam logic    CMD_EXTRACT = 1'b1;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;

	// Broadcast to every cell for the transfer being applied.
	typedef struct packed {
		logic ins;
		logic ext;
		key_t key;
	} op_t;

	// What a cell hands to its right-hand neighbor.
	typedef struct packed {
		logic ge;
		key_t key;
	} link_t;

endpackage

@@ rtl/core/mhpq_cell.sv @@
// One slot of the sorted key row (largest key at the left end).
// Depends on mhpq_pkg.
module mhpq_cell (
	input  logic           clk,
	input  mhpq_pkg::op_t   op,
	input  logic           occ,
	input  mhpq_pkg::link_t left,
	input  mhpq_pkg::key_t  right_key,
	output mhpq_pkg::link_t link
);
	import mhpq_pkg::*;

	key_t key_q;

	// Slots are ordered, so ge forms a prefix along the row.
	assign link.ge  = occ && (key_q >= op.key);
	assign link.key = key_q;

	always_ff @(posedge clk) begin
		if (op.ins) begin
			if (!link.ge) begin
				key_q <= left.ge ? op.key : left.key;
			end
		end else if (op.ext) begin
			key_q <= right_key;
		end
	end

endmodule

@@ rtl/core/max_heap_priority_queue.sv @@
// Top level of the max-heap priority queue: a row of mhpq_cell slots plus
// the entry count and result register. Depends on mhpq_pkg and mhpq_cell.
//
// The row of cells compares the new key in every slot at once and shifts in
// a single step, so busy stays low and a new command may follow on every
// clock. The result shows on status, max_key and entry_count with done
// high in the cycle after the command is taken; the receiver cannot stall
// it. Inserting into a full queue reports full and drops the key;
// extracting from an empty queue reports empty. max_key is zero except on
// a successful extract.
module max_heap_priority_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              command,
	input  mhpq_pkg::key_t    key,
	output logic              done,
	output mhpq_pkg::status_t status,
	output mhpq_pkg::key_t    max_key,
	output mhpq_pkg::cnt_t    entry_count
);
	import mhpq_pkg::*;

	cnt_t    cnt_q;
	logic    done_q;
	status_t status_q;
	key_t    max_key_q;

	logic  take;
	logic  is_ins;
	logic  is_ext;
	logic  full;
	logic  empty;
	op_t   op;
	link_t links [CAPACITY];

	assign busy  = 1'b0;
	assign take  = start && !busy;
	assign full  = (cnt_q == CNT_W'(CAPACITY));
	assign empty = (cnt_q == '0);
	assign is_ins = take && (command == CMD_INSERT) && !full;
	assign is_ext = take && (command == CMD_EXTRACT) && !empty;

	assign op.ins = is_ins;
	assign op.ext = is_ext;
	assign op.key = key;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		link_t left_l;
		key_t  right_k;
		logic  occ;

		assign occ = (cnt_q > CNT_W'(i));
		if (i == 0) begin : g_head
			assign left_l = '{ge: 1'b1, key: '0};
		end else begin : g_body
			assign left_l = links[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_k = '0;
		end else begin : g_inner
			assign right_k = links[i+1].key;
		end

		mhpq_cell u_cell (
			.clk       (clk),
			.op        (op),
			.occ       (occ),
			.left      (left_l),
			.right_key (right_k),
			.link      (links[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= take;
			if (is_ins) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (is_ext) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (command == CMD_INSERT) begin
				status_q  <= full ? ST_FULL : ST_OK;
				max_key_q <= '0;
			end else begin
				status_q  <= empty ? ST_EMPTY : ST_OK;
				max_key_q <= empty ? key_t'(0) : links[0].key;
			end
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign max_key     = max_key_q;
	assign entry_count = cnt_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_done_follows_take: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> done)
		else $error("accepted command gave no result");

	a_err_zero_key: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> max_key == '0)
		else $error("error result carries a key");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		take && command == CMD_INSERT && full |=> $stable(cnt_q) && status == ST_FULL)
		else $error("insert into full queue changed the count");

	a_ext_count: assert property (@(posedge clk) disable iff (!arst_n)
		is_ext |=> cnt_q == $past(cnt_q) - CNT_W'(1))
		else $error("extract did not drop the count");

endmodule
